@@ hw/rtl/ptf_pkg.sv @@
// ptf_pkg: constants and types shared by the pressure trend forecast block
// depends on nothing

package ptf_pkg;

  localparam int PRESS_W = 17;
  localparam int RAIN_W = 8;

  localparam int WINDOW_LEN_DEF = 6;
  localparam int BATCH_LEN_DEF = 10;

  localparam logic FUNC_INIT = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // trend span in pascals that maps onto the full rain range
  localparam int TREND_SPAN = 250;
  localparam int RAIN_MAX = 100;

  // floor(n / 5) = (n * 205) >> 10 for n < 1024
  localparam int DIV5_MUL = 205;
  localparam int DIV5_SH = 10;

  typedef struct packed {
    logic init;
    logic upd;
  } ptf_flags_t;

endpackage

@@ hw/rtl/pressure_trend_forecast.sv @@
// pressure_trend_forecast: batch averaging, window slope and rain figure mapping
// depends on ptf_pkg

// Usage
//   in_ channel: one word per pressure reading; in_func selects an init word
//   (window filled with the reading, rain figure cleared, open batch dropped)
//   or an ordinary reading. A word is taken when in_valid is high and
//   in_stall is low.
//   out_ channel: exactly one word per input word, in order: the rain figure
//   after that word and a flag that is set when the word closed a batch.
// Pipeline: input register, batch mean multiply, window slope, divide by the
//   slope denominator, rain map.
// Throughput: one word per cycle while out_stall is low; every stage is a single register step.
// Stall: when out_stall holds a result, earlier stages keep filling; in_stall
//   rises only when all five stages hold a word.
// Reset: synchronous active-low; window, batch sum, count and rain figure
//   clear to zero, pipeline empties.

module pressure_trend_forecast
  import ptf_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int BATCH_LEN = BATCH_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_func,
  input  logic [PRESS_W-1:0]       in_pressure_pa,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [RAIN_W-1:0] out_rain_percent,
  output logic                     out_window_updated
);

  // batch accumulation and mean by reciprocal multiply
  localparam int CNT_W = $clog2(BATCH_LEN + 1);
  localparam int BL_W = $clog2(BATCH_LEN);
  localparam int SUM_W = PRESS_W + BL_W;
  localparam int MEAN_SH = SUM_W + BL_W;
  localparam int MMUL_W = SUM_W + 1;
  localparam int MPROD_W = SUM_W + MMUL_W;
  localparam logic [63:0] MEAN_MUL64 =
    ((64'd1 << MEAN_SH) + 64'(BATCH_LEN) - 64'd1) / 64'(BATCH_LEN);
  localparam logic [MMUL_W-1:0] MEAN_MUL = MEAN_MUL64[MMUL_W-1:0];

  // least-squares slope constants
  localparam int SX = WINDOW_LEN * (WINDOW_LEN - 1) / 2;
  localparam int SXX = (WINDOW_LEN - 1) * WINDOW_LEN * (2 * WINDOW_LEN - 1) / 6;
  localparam int DEN = WINDOW_LEN * SXX - SX * SX;
  localparam int SY_W = PRESS_W + $clog2(WINDOW_LEN);
  localparam int SXY_W = PRESS_W + $clog2(SX + 1);
  localparam int NUM_W = PRESS_W + $clog2(WINDOW_LEN * WINDOW_LEN * SX + 1) + 1;
  localparam logic signed [NUM_W-1:0] N_S = NUM_W'(WINDOW_LEN);
  localparam logic signed [NUM_W-1:0] SX_S = NUM_W'(SX);
  localparam logic signed [NUM_W-1:0] SAT_HI = NUM_W'(TREND_SPAN * DEN);
  localparam logic signed [NUM_W-1:0] SAT_LO = -SAT_HI;

  // delta = num / DEN by reciprocal multiply, only below saturation
  localparam int ABS_W = $clog2(TREND_SPAN * DEN);
  localparam int DL_W = $clog2(DEN);
  localparam int DIV_SH = ABS_W + DL_W;
  localparam int DMUL_W = ABS_W + 1;
  localparam int DPROD_W = ABS_W + DMUL_W;
  localparam int Q_W = $clog2(TREND_SPAN);
  localparam logic [63:0] DMUL64 = ((64'd1 << DIV_SH) + 64'(DEN) - 64'd1) / 64'(DEN);
  localparam logic [DMUL_W-1:0] DMUL = DMUL64[DMUL_W-1:0];
  localparam int D_W = Q_W + 2;
  localparam int X_W = $clog2(2 * TREND_SPAN);
  localparam int T_W = X_W + 1 + $clog2(DIV5_MUL);

  // handshake chain
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;
  logic rdy_out, rdy4, rdy3, rdy2, rdy1;
  logic mv1, mv2, mv3, mv4;

  // stage registers
  logic               s1_func_r;
  logic [PRESS_W-1:0] s1_p_r;
  logic [SUM_W-1:0]   bsum_r, bsum_nxt, total;
  logic [CNT_W-1:0]   bcnt_r, bcnt_nxt;
  ptf_flags_t         s2_flags_r, s2_flags_nxt;
  logic [PRESS_W-1:0] s2_p_r;
  logic [MPROD_W-1:0] s2_prod_r;
  logic [PRESS_W-1:0] win_r [WINDOW_LEN];
  logic [PRESS_W-1:0] win_nxt [WINDOW_LEN];
  logic [PRESS_W-1:0] mean;
  logic [SY_W-1:0]    sy;
  logic [SXY_W-1:0]   sxy;
  logic signed [NUM_W-1:0] num_nxt;
  ptf_flags_t         s3_flags_r;
  logic signed [NUM_W-1:0] s3_num_r;
  logic [NUM_W-1:0]   num_abs;
  ptf_flags_t         s4_flags_r;
  logic               s4_sat_hi_r, s4_sat_lo_r, s4_neg_r;
  logic [DPROD_W-1:0] s4_prod_r;
  logic [Q_W-1:0]     q;
  logic signed [D_W-1:0] delta;
  logic signed [D_W-1:0] xs;
  logic [X_W-1:0]     x;
  logic [T_W-1:0]     t_full;
  logic [RAIN_W-1:0]  t;
  logic signed [RAIN_W-1:0] rain_calc;
  logic signed [RAIN_W-1:0] rain_r, rain_nxt;
  logic               out_upd_r;

  assign rdy_out = !out_valid_r || !out_stall;
  assign rdy4 = !s4_v_r || rdy_out;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign mv1 = s1_v_r && rdy2;
  assign mv2 = s2_v_r && rdy3;
  assign mv3 = s3_v_r && rdy4;
  assign mv4 = s4_v_r && rdy_out;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && rdy1) begin
        s1_v_r <= 1'b1;
      end else if (mv1) begin
        s1_v_r <= 1'b0;
      end
      if (mv1) begin
        s2_v_r <= 1'b1;
      end else if (mv2) begin
        s2_v_r <= 1'b0;
      end
      if (mv2) begin
        s3_v_r <= 1'b1;
      end else if (mv3) begin
        s3_v_r <= 1'b0;
      end
      if (mv3) begin
        s4_v_r <= 1'b1;
      end else if (mv4) begin
        s4_v_r <= 1'b0;
      end
      if (mv4) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      s1_func_r <= in_func;
      s1_p_r <= in_pressure_pa;
    end
  end

  // batch accumulation
  assign total = bsum_r + SUM_W'(s1_p_r);

  always_comb begin
    bsum_nxt = total;
    bcnt_nxt = bcnt_r + CNT_W'(1);
    s2_flags_nxt.init = 1'b0;
    s2_flags_nxt.upd = 1'b0;
    if (s1_func_r == FUNC_INIT) begin
      bsum_nxt = '0;
      bcnt_nxt = '0;
      s2_flags_nxt.init = 1'b1;
    end else if (bcnt_r == CNT_W'(BATCH_LEN - 1)) begin
      bsum_nxt = '0;
      bcnt_nxt = '0;
      s2_flags_nxt.upd = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsum_r <= '0;
      bcnt_r <= '0;
    end else if (mv1) begin
      bsum_r <= bsum_nxt;
      bcnt_r <= bcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      s2_flags_r <= s2_flags_nxt;
      s2_p_r <= s1_p_r;
      s2_prod_r <= MPROD_W'(total) * MPROD_W'(MEAN_MUL);
    end
  end

  // window update and slope numerator
  assign mean = s2_prod_r[MEAN_SH +: PRESS_W];

  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (s2_flags_r.init) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_nxt[i] = s2_p_r;
      end
    end else if (s2_flags_r.upd) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        win_nxt[i] = win_r[i + 1];
      end
      win_nxt[WINDOW_LEN - 1] = mean;
    end
  end

  always_comb begin
    sy = '0;
    sxy = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      sy = sy + SY_W'(win_nxt[i]);
      sxy = sxy + SXY_W'(i) * SXY_W'(win_nxt[i]);
    end
    num_nxt = N_S * (N_S * $signed(NUM_W'(sxy)) - SX_S * $signed(NUM_W'(sy)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else if (mv2) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv2) begin
      s3_flags_r <= s2_flags_r;
      s3_num_r <= num_nxt;
    end
  end

  // saturation test and reciprocal multiply for the slope divide
  assign num_abs = s3_num_r[NUM_W-1] ? NUM_W'(-s3_num_r) : NUM_W'(s3_num_r);

  always_ff @(posedge clk) begin
    if (mv3) begin
      s4_flags_r <= s3_flags_r;
      s4_sat_hi_r <= (s3_num_r >= SAT_HI);
      s4_sat_lo_r <= (s3_num_r <= SAT_LO);
      s4_neg_r <= s3_num_r[NUM_W-1];
      s4_prod_r <= DPROD_W'(num_abs[ABS_W-1:0]) * DPROD_W'(DMUL);
    end
  end

  // rain mapping: 100 - floor(2 * (delta + 250) / 5)
  always_comb begin
    q = s4_prod_r[DIV_SH +: Q_W];
    delta = s4_neg_r ? -$signed(D_W'(q)) : $signed(D_W'(q));
    xs = delta + D_W'(TREND_SPAN);
    x = xs[X_W-1:0];
    t_full = T_W'({x, 1'b0}) * T_W'(DIV5_MUL);
    t = t_full[DIV5_SH +: RAIN_W];
    rain_calc = $signed(RAIN_W'(RAIN_MAX) - t);
    if (s4_sat_hi_r) begin
      rain_calc = -$signed(RAIN_W'(RAIN_MAX));
    end else if (s4_sat_lo_r) begin
      rain_calc = $signed(RAIN_W'(RAIN_MAX));
    end
    rain_nxt = rain_r;
    if (s4_flags_r.init) begin
      rain_nxt = '0;
    end else if (s4_flags_r.upd) begin
      rain_nxt = rain_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rain_r <= '0;
    end else if (mv4) begin
      rain_r <= rain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mv4) begin
      out_upd_r <= s4_flags_r.upd;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rain_percent = rain_r;
  assign out_window_updated = out_upd_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r < CNT_W'(BATCH_LEN))
    else $error("batch count out of range");

  a_rain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (rain_r <= $signed(RAIN_W'(RAIN_MAX)) &&
                     rain_r >= -$signed(RAIN_W'(RAIN_MAX))))
    else $error("rain figure out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && s3_v_r && s4_v_r && out_valid_r))
    else $error("input stalled with a free stage");

  a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (mv4 && s4_flags_r.init) |=> (rain_r == '0 && !out_upd_r))
    else $error("init word did not clear rain figure");

endmodule

@@ tb/pressure_trend_forecast_tb.sv @@
// pressure_trend_forecast_tb: self-checking bench for the pressure trend forecast block
// predicts every result word from its own copy of window, batch and rain state
// depends on ptf_pkg and pressure_trend_forecast

module pressure_trend_forecast_tb;
  import ptf_pkg::*;

  typedef struct {
    logic               func;
    logic [PRESS_W-1:0] pa;
    bit                 drain_first;
  } reading_t;

  typedef struct {
    logic signed [RAIN_W-1:0] rain;
    logic                     upd;
  } rain_word_t;

  localparam longint PA_TOP = (1 << PRESS_W) - 1;
  localparam int CALM_TAIL = 100;
  localparam int LONG_HOLD = 60;
  localparam int LONG_HOLD_AT = 400;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_func = FUNC_INIT;
  logic [PRESS_W-1:0]       in_pressure_pa = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [RAIN_W-1:0] out_rain_percent;
  logic                     out_window_updated;

  reading_t   readings_q[$];
  rain_word_t rain_words_q[$];

  logic [PRESS_W-1:0]       hist_win[WINDOW_LEN_DEF];
  int unsigned              batch_acc;
  int                       batch_cnt;
  logic signed [RAIN_W-1:0] rain_fig;

  bit word_taken = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int long_hold_left = 0;
  bit long_hold_done = 1'b0;
  int results_seen = 0;
  int errors = 0;

  pressure_trend_forecast u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_pressure_pa    (in_pressure_pa),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rain_percent  (out_rain_percent),
    .out_window_updated(out_window_updated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [PRESS_W-1:0] pa_clamp(input longint v);
    if (v < 0) begin
      return '0;
    end
    if (v > PA_TOP) begin
      return PRESS_W'(PA_TOP);
    end
    return PRESS_W'(v);
  endfunction

  function automatic rain_word_t forecast(input logic func, input logic [PRESS_W-1:0] pa);
    rain_word_t res;
    longint n, p, sx, sxx, sy, sxy, num, den, delta, fig;
    res.upd = 1'b0;
    if (func == FUNC_INIT) begin
      foreach (hist_win[i]) hist_win[i] = pa;
      rain_fig = '0;
      batch_acc = 0;
      batch_cnt = 0;
    end else begin
      batch_acc += pa;
      batch_cnt++;
      if (batch_cnt >= BATCH_LEN_DEF) begin
        for (int i = 0; i + 1 < WINDOW_LEN_DEF; i++) hist_win[i] = hist_win[i + 1];
        hist_win[WINDOW_LEN_DEF - 1] = PRESS_W'(batch_acc / BATCH_LEN_DEF);
        batch_acc = 0;
        batch_cnt = 0;
        n = WINDOW_LEN_DEF;
        sx = 0;
        sxx = 0;
        sy = 0;
        sxy = 0;
        for (int i = 0; i < WINDOW_LEN_DEF; i++) begin
          p = longint'(hist_win[i]);
          sx += i;
          sxx += longint'(i) * i;
          sy += p;
          sxy += longint'(i) * p;
        end
        num = n * (n * sxy - sx * sy);
        den = n * sxx - sx * sx;
        delta = (den != 0) ? num / den : 0;
        fig = (delta + TREND_SPAN) * (-2 * RAIN_MAX) / (2 * TREND_SPAN) + RAIN_MAX;
        if (fig > RAIN_MAX) fig = RAIN_MAX;
        if (fig < -RAIN_MAX) fig = -RAIN_MAX;
        rain_fig = fig[RAIN_W-1:0];
        res.upd = 1'b1;
      end
    end
    res.rain = rain_fig;
    return res;
  endfunction

  task automatic put_reading(input logic func, input logic [PRESS_W-1:0] pa,
                             input bit drain_first = 1'b0);
    reading_t r;
    r.func = func;
    r.pa = pa;
    r.drain_first = drain_first;
    readings_q.push_back(r);
  endtask

  task automatic put_batch(input logic [PRESS_W-1:0] pa);
    for (int k = 0; k < BATCH_LEN_DEF; k++) put_reading(FUNC_READ, pa);
  endtask

  // init then several batches with a steady drift and per-reading jitter
  task automatic put_trend_run(input bit drain_first);
    longint level;
    int drift, spread, batches;
    level = $urandom_range(0, 7) == 0 ? ($urandom_range(0, 1) ? PA_TOP : 0)
                                      : longint'($urandom_range(0, int'(PA_TOP)));
    drift = int'($urandom_range(0, 140)) - 70;
    spread = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(1, 300));
    batches = $urandom_range(1, 8);
    put_reading(FUNC_INIT, pa_clamp(level), drain_first);
    for (int b = 0; b < batches; b++) begin
      level += drift;
      for (int k = 0; k < BATCH_LEN_DEF; k++) begin
        if ($urandom_range(0, 60) == 0) begin
          put_reading(FUNC_INIT, pa_clamp(level));
        end else begin
          put_reading(FUNC_READ,
                      pa_clamp(level + int'($urandom_range(0, 2 * spread)) - spread));
        end
      end
    end
  endtask

  task automatic put_noise();
    int cnt;
    cnt = $urandom_range(1, 12);
    for (int k = 0; k < cnt; k++) begin
      put_reading($urandom_range(0, 1) ? FUNC_READ : FUNC_INIT, PRESS_W'($urandom));
    end
  endtask

  // driver
  always @(negedge clk) begin : drive
    reading_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !word_taken) begin
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (readings_q.size() == 0) begin
      in_valid <= 1'b0;
    end else if (readings_q[0].drain_first && (in_valid || rain_words_q.size() != 0)) begin
      in_valid <= 1'b0;
    end else if (readings_q.size() > CALM_TAIL && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      send_gap <= $urandom_range(0, 17);
    end else begin
      nxt = readings_q.pop_front();
      in_valid <= 1'b1;
      in_func <= nxt.func;
      in_pressure_pa <= nxt.pa;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (long_hold_left > 0) begin
      out_stall <= 1'b1;
      long_hold_left <= long_hold_left - 1;
    end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
      out_stall <= 1'b1;
      long_hold_done <= 1'b1;
      long_hold_left <= LONG_HOLD - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (readings_q.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 17);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // prediction on accept, compare on result
  always @(posedge clk) begin : watch
    rain_word_t want;
    word_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        rain_words_q.push_back(forecast(in_func, in_pressure_pa));
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (rain_words_q.size() == 0) begin
          $error("result word with nothing expected: rain_percent %0d window_updated %0d",
                 out_rain_percent, out_window_updated);
          errors++;
        end else begin
          want = rain_words_q.pop_front();
          if (out_rain_percent !== want.rain) begin
            $error("rain_percent: expected %0d, got %0d", want.rain, out_rain_percent);
            errors++;
          end
          if (out_window_updated !== want.upd) begin
            $error("window_updated: expected %0d, got %0d", want.upd, out_window_updated);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    bit drained;
    foreach (hist_win[i]) hist_win[i] = '0;
    batch_acc = 0;
    batch_cnt = 0;
    rain_fig = '0;

    // partial batch dropped by init, then full-scale rise and fall
    put_reading(FUNC_INIT, '0);
    repeat (3) put_reading(FUNC_READ, PRESS_W'(PA_TOP));
    put_reading(FUNC_INIT, '0);
    put_batch(PRESS_W'(PA_TOP));
    put_reading(FUNC_INIT, PRESS_W'(PA_TOP));
    put_batch('0);

    drained = 1'b0;
    while (readings_q.size() < 1830) begin
      if ($urandom_range(0, 6) == 0) begin
        put_noise();
      end else begin
        put_trend_run(!drained && readings_q.size() >= 900);
        if (readings_q.size() >= 900) drained = 1'b1;
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait (readings_q.size() == 0 && !in_valid);
    wait (rain_words_q.size() == 0);
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
